// ===== hw/rtl/tft_rect_fill_byte_sequencer_assert.svh =====
// assertion macros used by the byte sequencer state module (tfs_seq)
`ifndef TFT_RECT_FILL_BYTE_SEQUENCER_ASSERT_SVH
`define TFT_RECT_FILL_BYTE_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tfs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tfs assertion failed");

`endif

// ===== hw/rtl/tfs_pkg.sv =====
// shared types and constants of the rectangle fill byte sequencer
package tfs_pkg;

	// request kinds carried on the input tuser bit
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// panel command bytes
	localparam logic [7:0] CMD_COLUMN = 8'h2A;
	localparam logic [7:0] CMD_ROW    = 8'h2B;
	localparam logic [7:0] CMD_WRITE  = 8'h2C;

	// header step positions
	localparam logic [3:0] STEP_CMD_COLUMN = 4'd0;
	localparam logic [3:0] STEP_CMD_ROW    = 4'd5;
	localparam logic [3:0] STEP_CMD_WRITE  = 4'd10;
	localparam logic [3:0] STEP_PIXELS     = 4'd11;

	// address window sent in the header
	typedef struct packed {
		logic [15:0] y1;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] x0;
	} window_t;

	// one byte of the panel stream
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last_byte;
	} pkt_t;

endpackage

// ===== hw/rtl/tft_rect_fill_byte_sequencer.sv =====
// Rectangle fill byte sequencer: turns fill requests and byte slot ticks into
// the panel byte stream (column window, row window, memory write, pixels).
// Input channel: s_axis_tuser selects a start request (0) or a byte slot tick
// (1); a start carries the rectangle and colour on s_axis_tdata. A start whose
// origin is off the panel, or that arrives while a fill runs, is dropped.
// Output channel: one byte per tick while a fill runs; m_axis_tuser is the
// data/command level, m_axis_tlast marks the last byte of the fill.
// The byte for a tick is registered and valid on the output in the cycle after
// the tick transfer. Throughput: one input transfer per cycle while the output
// is not stalled, set by the single output register that holds one byte.
// Stall: while the output byte waits, s_axis_tready stays low; it is high
// again in the cycle the byte is taken, so transfers continue without a gap.
// Reset: the block is idle with an empty output register; ticks yield nothing
// until a start is taken.
module tft_rect_fill_byte_sequencer
	import tfs_pkg::*;
#(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // rect_x, rect_y, rect_w, rect_h, fill_color
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_byte
	output logic        m_axis_tuser,  // is_data
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(PANEL_WIDTH + 1);
	localparam int RW = $clog2(PANEL_HEIGHT + 1);

	logic          in_fire;
	logic          origin_ok;
	window_t       win;
	logic [CW-1:0] cols;
	logic [RW-1:0] rows;
	logic          res_valid;
	pkt_t          res;
	pkt_t          pkt;
	logic          free;

	assign s_axis_tready = free;
	assign in_fire       = s_axis_tvalid && free;

	// request clipping
	tfs_clip #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_clip (
		.rect_x   (s_axis_tdata[15:0]),
		.rect_y   (s_axis_tdata[31:16]),
		.rect_w   (s_axis_tdata[47:32]),
		.rect_h   (s_axis_tdata[63:48]),
		.origin_ok(origin_ok),
		.win      (win),
		.cols     (cols),
		.rows     (rows)
	);

	// byte sequencer
	tfs_seq #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.mode      (s_axis_tuser),
		.fill_color(s_axis_tdata[79:64]),
		.origin_ok (origin_ok),
		.win       (win),
		.cols      (cols),
		.rows      (rows),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register
	tfs_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.free         (free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.pkt          (pkt)
	);

	assign m_axis_tdata = pkt.out_byte;
	assign m_axis_tuser = pkt.is_data;
	assign m_axis_tlast = pkt.last_byte;

endmodule

// ===== hw/rtl/tfs_clip.sv =====
// origin check and edge clipping of a fill request
module tfs_clip
	import tfs_pkg::*;
#(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320,
	localparam int CW = $clog2(PANEL_WIDTH + 1),
	localparam int RW = $clog2(PANEL_HEIGHT + 1)
) (
	input  logic [15:0]   rect_x,
	input  logic [15:0]   rect_y,
	input  logic [15:0]   rect_w,
	input  logic [15:0]   rect_h,
	output logic          origin_ok,
	output window_t       win,
	output logic [CW-1:0] cols,
	output logic [RW-1:0] rows
);

	localparam logic [16:0] PW17 = 17'(PANEL_WIDTH);
	localparam logic [16:0] PH17 = 17'(PANEL_HEIGHT);

	logic [16:0] x_end;
	logic [16:0] y_end;
	logic [16:0] w_cut;
	logic [16:0] h_cut;
	logic [16:0] x1_sum;
	logic [16:0] y1_sum;

	// origin must lie on the panel
	assign origin_ok = ({1'b0, rect_x} < PW17) && ({1'b0, rect_y} < PH17);

	// clip a nonzero extent that runs past the edge
	assign x_end = {1'b0, rect_x} + {1'b0, rect_w};
	assign y_end = {1'b0, rect_y} + {1'b0, rect_h};
	assign w_cut = ((rect_w != 16'd0) && (x_end > PW17)) ? (PW17 - {1'b0, rect_x})
		: {1'b0, rect_w};
	assign h_cut = ((rect_h != 16'd0) && (y_end > PH17)) ? (PH17 - {1'b0, rect_y})
		: {1'b0, rect_h};
	assign cols = w_cut[CW-1:0];
	assign rows = h_cut[RW-1:0];

	// end coordinates wrap when the extent is zero
	assign x1_sum = {1'b0, rect_x} + 17'(cols) - 17'd1;
	assign y1_sum = {1'b0, rect_y} + 17'(rows) - 17'd1;
	assign win.x0 = rect_x;
	assign win.x1 = x1_sum[15:0];
	assign win.y0 = rect_y;
	assign win.y1 = y1_sum[15:0];

endmodule

// ===== hw/rtl/tfs_seq.sv =====
// header and pixel byte sequencer state
`include "tft_rect_fill_byte_sequencer_assert.svh"
module tfs_seq
	import tfs_pkg::*;
#(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320,
	localparam int CW = $clog2(PANEL_WIDTH + 1),
	localparam int RW = $clog2(PANEL_HEIGHT + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          mode,
	input  logic [15:0]   fill_color,
	input  logic          origin_ok,
	input  window_t       win,
	input  logic [CW-1:0] cols,
	input  logic [RW-1:0] rows,
	output logic          res_valid,
	output pkt_t          res
);

	logic          busy_q,  busy_d;
	logic [3:0]    step_q,  step_d;
	logic          low_q,   low_d;
	logic          empty_q, empty_d;
	logic [CW-1:0] col_left_q, col_left_d;
	logic [RW-1:0] row_left_q, row_left_d;
	logic [CW-1:0] cols_q;
	window_t       win_q;
	logic [15:0]   color_q;
	logic          load;
	logic [15:0]   hdr_word;
	logic          hdr_high;

	assign load = in_fire && (mode == MODE_START) && !busy_q && origin_ok;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= STEP_CMD_COLUMN;
			low_q      <= 1'b0;
			empty_q    <= 1'b0;
			col_left_q <= '0;
			row_left_q <= '0;
		end else begin
			busy_q     <= busy_d;
			step_q     <= step_d;
			low_q      <= low_d;
			empty_q    <= empty_d;
			col_left_q <= col_left_d;
			row_left_q <= row_left_d;
		end
	end

	// request payload, written on every accepted start
	always_ff @(posedge clk) begin
		if (load) begin
			win_q   <= win;
			color_q <= fill_color;
			cols_q  <= cols;
		end
	end

	// window word for coordinate steps
	always_comb begin
		if (step_q < STEP_CMD_ROW) begin
			hdr_word = (step_q < 4'd3) ? win_q.x0 : win_q.x1;
			hdr_high = step_q[0];
		end else begin
			hdr_word = (step_q < 4'd8) ? win_q.y0 : win_q.y1;
			hdr_high = !step_q[0];
		end
	end

	// next state and result byte
	always_comb begin
		busy_d     = busy_q;
		step_d     = step_q;
		low_d      = low_q;
		empty_d    = empty_q;
		col_left_d = col_left_q;
		row_left_d = row_left_q;
		res_valid  = 1'b0;
		res.out_byte  = hdr_high ? hdr_word[15:8] : hdr_word[7:0];
		res.is_data   = 1'b1;
		res.last_byte = 1'b0;
		if (load) begin
			busy_d     = 1'b1;
			step_d     = STEP_CMD_COLUMN;
			low_d      = 1'b0;
			empty_d    = (cols == '0) || (rows == '0);
			col_left_d = cols;
			row_left_d = rows;
		end else if (in_fire && (mode == MODE_TICK) && busy_q) begin
			res_valid = 1'b1;
			case (step_q)
				STEP_CMD_COLUMN: begin
					res.out_byte = CMD_COLUMN;
					res.is_data  = 1'b0;
					step_d       = step_q + 4'd1;
				end
				STEP_CMD_ROW: begin
					res.out_byte = CMD_ROW;
					res.is_data  = 1'b0;
					step_d       = step_q + 4'd1;
				end
				STEP_CMD_WRITE: begin
					res.out_byte = CMD_WRITE;
					res.is_data  = 1'b0;
					if (empty_q) begin
						res.last_byte = 1'b1;
						busy_d        = 1'b0;
						step_d        = STEP_CMD_COLUMN;
					end else begin
						step_d = STEP_PIXELS;
					end
				end
				STEP_PIXELS: begin
					res.out_byte = low_q ? color_q[7:0] : color_q[15:8];
					low_d        = !low_q;
					if (low_q) begin
						if (col_left_q == CW'(1)) begin
							if (row_left_q == RW'(1)) begin
								res.last_byte = 1'b1;
								busy_d        = 1'b0;
								step_d        = STEP_CMD_COLUMN;
								low_d         = 1'b0;
								col_left_d    = '0;
								row_left_d    = '0;
							end else begin
								row_left_d = row_left_q - RW'(1);
								col_left_d = cols_q;
							end
						end else begin
							col_left_d = col_left_q - CW'(1);
						end
					end
				end
				default: begin
					step_d = step_q + 4'd1;
				end
			endcase
		end
	end

	// checks on the sequencer state
	`TFS_ASSERT_NOW(a_idle_at_step0, clk, arst_n, !busy_q, (step_q == STEP_CMD_COLUMN) && !low_q)
	`TFS_ASSERT_NOW(a_step_range, clk, arst_n, busy_q, step_q <= STEP_PIXELS)
	`TFS_ASSERT_NOW(a_low_in_pixels, clk, arst_n, low_q, step_q == STEP_PIXELS)
	`TFS_ASSERT_NEXT(a_last_ends_run, clk, arst_n, res_valid && res.last_byte, !busy_q)

endmodule

// ===== hw/rtl/tfs_out_reg.sv =====
// output register of the byte stream with transfer handshake
module tfs_out_reg
	import tfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  pkt_t res,
	output logic free,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output pkt_t pkt
);

	logic valid_q;
	pkt_t pkt_q;

	// register can take a new byte when empty or draining this cycle
	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (free && res_valid) begin
			pkt_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign pkt           = pkt_q;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the rectangle fill byte sequencer: directed and random fills
`timescale 1ns / 100ps

module testbench;
	import tfs_pkg::*;

	localparam int PANEL_W      = 240;
	localparam int PANEL_H      = 320;
	localparam int HEADER_BYTES = 11;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int SEGMENTS     = 8;
	localparam int SEGMENT_LEN  = 80;

	// one request waiting for the input side
	typedef struct {
		logic        mode;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] color;
		int unsigned gap;
		bit          drain_first;
		bit          hold_rx;
	} req_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;  // rect_x, rect_y, rect_w, rect_h, fill_color
	logic        s_axis_tuser = 1'b0;  // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // out_byte
	logic        m_axis_tuser;  // is_data
	logic        m_axis_tlast;

	req_t        pending[$];
	req_t        req_on_bus;
	pkt_t        bytes_due[$];
	int unsigned tx_idle = 0;
	int unsigned tx_max = 7;
	int unsigned rx_max = 7;
	int unsigned rx_wait = 0;
	logic        rx_hold = 1'b0;
	logic        rx_hold_req = 1'b0;
	bit          mark_drain = 1'b0;
	bit          mark_hold = 1'b0;
	int unsigned errors = 0;
	int unsigned requests_taken = 0;
	int unsigned bytes_seen = 0;
	int unsigned fills_queued = 0;
	int unsigned fill_items = 0;

	// predicted sequencer state
	logic        fill_busy = 1'b0;
	logic [3:0]  hdr_step = STEP_CMD_COLUMN;
	window_t     win = '0;
	logic [16:0] px_left = '0;
	logic        low_next = 1'b0;
	logic [15:0] color_q = '0;

	tft_rect_fill_byte_sequencer #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// apply one accepted request to the predicted state, queue the byte it yields
	function automatic void advance_panel_stream(input req_t r);
		pkt_t        p;
		int unsigned cw;
		int unsigned ch;
		logic [3:0]  off;
		logic [15:0] word;
		if (r.mode == MODE_START) begin
			if (fill_busy || r.x >= PANEL_W || r.y >= PANEL_H)
				return;
			cw = r.w;
			ch = r.h;
			// clip to the panel edge, zero sizes stay zero
			if (cw != 0 && r.x + cw > PANEL_W)
				cw = PANEL_W - r.x;
			if (ch != 0 && r.y + ch > PANEL_H)
				ch = PANEL_H - r.y;
			win.x0 = r.x;
			win.x1 = 16'(r.x + cw - 1);
			win.y0 = r.y;
			win.y1 = 16'(r.y + ch - 1);
			px_left = 17'(cw * ch);
			color_q = r.color;
			low_next = 1'b0;
			hdr_step = STEP_CMD_COLUMN;
			fill_busy = 1'b1;
			return;
		end
		if (!fill_busy)
			return;
		p.is_data = 1'b1;
		p.last_byte = 1'b0;
		if (hdr_step < STEP_PIXELS) begin
			case (hdr_step)
				STEP_CMD_COLUMN: begin
					p.out_byte = CMD_COLUMN;
					p.is_data = 1'b0;
				end
				STEP_CMD_ROW: begin
					p.out_byte = CMD_ROW;
					p.is_data = 1'b0;
				end
				STEP_CMD_WRITE: begin
					p.out_byte = CMD_WRITE;
					p.is_data = 1'b0;
				end
				default: begin
					// window words go out high byte first
					if (hdr_step < STEP_CMD_ROW) begin
						off = hdr_step - STEP_CMD_COLUMN - 4'd1;
						word = off[1] ? win.x1 : win.x0;
					end else begin
						off = hdr_step - STEP_CMD_ROW - 4'd1;
						word = off[1] ? win.y1 : win.y0;
					end
					p.out_byte = off[0] ? word[7:0] : word[15:8];
				end
			endcase
			if (hdr_step == STEP_CMD_WRITE) begin
				if (px_left == 0) begin
					p.last_byte = 1'b1;
					fill_busy = 1'b0;
					hdr_step = STEP_CMD_COLUMN;
				end else begin
					hdr_step = STEP_PIXELS;
				end
			end else begin
				hdr_step = hdr_step + 4'd1;
			end
		end else begin
			p.out_byte = low_next ? color_q[7:0] : color_q[15:8];
			if (low_next) begin
				low_next = 1'b0;
				px_left = px_left - 17'd1;
				if (px_left == 0) begin
					p.last_byte = 1'b1;
					fill_busy = 1'b0;
					hdr_step = STEP_CMD_COLUMN;
				end
			end else begin
				low_next = 1'b1;
			end
		end
		bytes_due.push_back(p);
	endfunction

	// bytes a well-formed fill needs, header plus two per clipped pixel
	function automatic int unsigned fill_ticks(input logic [15:0] x, y, w, h);
		int unsigned cw;
		int unsigned ch;
		cw = w;
		ch = h;
		if (cw != 0 && x + cw > PANEL_W)
			cw = PANEL_W - x;
		if (ch != 0 && y + ch > PANEL_H)
			ch = PANEL_H - y;
		return HEADER_BYTES + 2 * cw * ch;
	endfunction

	task automatic push_req(input logic mode, input logic [15:0] x, y, w, h, c);
		req_t r;
		r.mode = mode;
		r.x = x;
		r.y = y;
		r.w = w;
		r.h = h;
		r.color = c;
		r.gap = $urandom_range(0, tx_max);
		r.drain_first = mark_drain;
		r.hold_rx = mark_hold;
		mark_drain = 1'b0;
		mark_hold = 1'b0;
		pending.push_back(r);
	endtask

	task automatic push_tick();
		push_req(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// start plus exactly the ticks it needs, optionally a start while busy
	task automatic push_fill(input logic [15:0] x, y, w, h, c, input int busy_at);
		int unsigned n;
		n = fill_ticks(x, y, w, h);
		push_req(MODE_START, x, y, w, h, c);
		for (int i = 0; i < n; i++) begin
			if (i == busy_at)
				push_req(MODE_START, 16'($urandom_range(0, PANEL_W - 1)),
					16'($urandom_range(0, PANEL_H - 1)), 16'($urandom), 16'($urandom),
					16'($urandom));
			push_tick();
		end
		fill_items += 1 + n;
		fills_queued++;
	endtask

	// input side: present queued requests after their idle gap
	always @(posedge clk or negedge arst_n) begin : tx_side
		req_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_idle <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_panel_stream(req_on_bus);
				requests_taken++;
				if (req_on_bus.hold_rx)
					rx_hold_req <= 1'b1;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// transfer still waiting, keep it on the bus
			end else if (pending.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (tx_idle < pending[0].gap) begin
				tx_idle <= tx_idle + 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending[0].drain_first && bytes_due.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				r = pending.pop_front();
				req_on_bus <= r;
				s_axis_tdata <= {r.color, r.h, r.w, r.y, r.x};
				s_axis_tuser <= r.mode;
				s_axis_tvalid <= 1'b1;
				tx_idle <= 0;
			end
		end
	end

	task automatic check_field(input string what, input logic [7:0] want, got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// output side: random stalls, compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : rx_side
		int unsigned w;
		pkt_t        want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			w = rx_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				bytes_seen++;
				if (bytes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected byte, expected none, actual %h is_data %b last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = bytes_due.pop_front();
					check_field("out_byte", want.out_byte, m_axis_tdata);
					check_field("is_data", 8'(want.is_data), 8'(m_axis_tuser));
					check_field("last_byte", 8'(want.last_byte), 8'(m_axis_tlast));
				end
				w = $urandom_range(0, rx_max);
			end
			if (rx_hold || w != 0) begin
				m_axis_tready <= 1'b0;
				if (w != 0)
					w--;
			end else begin
				m_axis_tready <= 1'b1;
			end
			rx_wait <= w;
		end
	end

	// long receiver hold-off once the big fill has started
	initial begin : rx_hold_off
		wait (rx_hold_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : watchdog
		#8_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int unsigned seg_goal;
		int unsigned pick;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		int          busy_at;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle ticks, off-panel origins, extremes, zero sizes, busy starts
		push_tick();
		push_tick();
		push_req(MODE_START, PANEL_W, 0, 1, 1, 16'h1234);
		push_req(MODE_START, 0, PANEL_H, 1, 1, 16'h1234);
		push_req(MODE_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_tick();
		push_fill(0, 0, 1, 1, 16'h0000, -1);
		push_fill(PANEL_W - 1, PANEL_H - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1);
		push_fill(0, 0, 0, 3, 16'hA5A5, -1);
		push_fill(5, PANEL_H - 1, 2, 0, 16'h5A5A, -1);
		push_fill(0, 0, 0, 0, 16'h0FF0, -1);
		push_fill(PANEL_W - 2, 10, 3, 2, 16'hF00F, 4);
		push_fill(230, 310, 16'hFFFF, 16'hFFFF, 16'hC3C3, 15);
		push_tick();
		// large clipped fill, sender waits for the stream to empty, receiver holds off
		mark_drain = 1'b1;
		mark_hold = 1'b1;
		push_fill(228, 308, 16'hFFFF, 16'hFFFF, 16'h8001, -1);

		// random segments with alternating idle settings
		seg_goal = fill_items;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			while (pending.size() != 0)
				@(posedge clk);
			@(negedge clk);
			tx_max = (seg % 2 == 0) ? 7 : 0;
			rx_max = (seg % 4 < 2) ? 7 : 0;
			if (seg % 4 == 1)
				rx_max = 0;
			if (seg % 4 == 3)
				rx_max = 7;
			mark_drain = 1'b1;
			seg_goal += SEGMENT_LEN;
			while (fill_items < seg_goal) begin
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					// off-panel origin, dropped
					x = 16'($urandom_range(PANEL_W, 16'hFFFF));
					y = 16'($urandom);
					if (pick == 1) begin
						x = 16'($urandom);
						y = 16'($urandom_range(PANEL_H, 16'hFFFF));
					end
					push_req(MODE_START, x, y, 16'($urandom), 16'($urandom), 16'($urandom));
				end else if (pick == 2) begin
					push_tick();
				end else begin
					if (pick < 5) begin
						// one dimension runs far past the panel edge
						x = 16'($urandom_range(PANEL_W - 6, PANEL_W - 1));
						y = 16'($urandom_range(0, PANEL_H - 1));
						w = 16'($urandom);
						h = 16'($urandom_range(0, 4));
						if (pick == 4) begin
							x = 16'($urandom_range(0, PANEL_W - 1));
							y = 16'($urandom_range(PANEL_H - 6, PANEL_H - 1));
							w = 16'($urandom_range(0, 4));
							h = 16'($urandom);
						end
					end else begin
						x = 16'($urandom_range(0, PANEL_W - 1));
						y = 16'($urandom_range(0, PANEL_H - 1));
						w = 16'($urandom_range(0, 5));
						h = 16'($urandom_range(0, 5));
					end
					busy_at = -1;
					if ($urandom_range(0, 9) == 0)
						busy_at = $urandom_range(0, fill_ticks(x, y, w, h) - 1);
					push_fill(x, y, w, h, 16'($urandom), busy_at);
				end
			end
		end

		// drain and let the pipeline settle
		while (pending.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d requests accepted, %0d fills queued with clipped, empty and busy cases",
			requests_taken, fills_queued);
		$display("run: %0d panel bytes checked, %0d errors", bytes_seen, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tfs_pkg.sv
hw/rtl/tfs_clip.sv
hw/rtl/tfs_seq.sv
hw/rtl/tfs_out_reg.sv
hw/rtl/tft_rect_fill_byte_sequencer.sv
bench/testbench.sv
